// ----- sv/dibc_pkg.sv -----
// dibc_pkg: shared types, codes and helpers of the dual-index barcode classifier
// depends on nothing; imported by dibc_ram users and by the top level
`default_nettype none

package dibc_pkg;

   // fixed field widths of the request, response and csr ports
   localparam int LANE_W      = 4;
   localparam int SLOT_W      = 6;
   localparam int LEN_W       = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 4;

   // request kinds
   localparam logic REQ_LOAD     = 1'b0;
   localparam logic REQ_CLASSIFY = 1'b1;

   // csr register indexes
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_MISMATCH_SINGLE = 3'd0;
   localparam csr_index_type CSR_MISMATCH_DOUBLE = 3'd1;
   localparam csr_index_type CSR_READ_I7_LENGTH  = 3'd2;
   localparam csr_index_type CSR_READ_I5_LENGTH  = 3'd3;
   localparam csr_index_type CSR_REVERSE_I5      = 3'd4;

   // base codes
   localparam logic [2:0] BASE_A = 3'd0;
   localparam logic [2:0] BASE_C = 3'd1;
   localparam logic [2:0] BASE_G = 3'd2;
   localparam logic [2:0] BASE_T = 3'd3;
   localparam logic [2:0] BASE_N = 3'd4;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_DONE
   } state_type;

   // classification outcome codes
   typedef enum logic [2:0] {
      OUT_UNASSIGNED   = 3'd0,
      OUT_SINGLE       = 3'd1,
      OUT_DOUBLE       = 3'd2,
      OUT_SINGLE_AMBIG = 3'd3,
      OUT_DOUBLE_AMBIG = 3'd4
   } outcome_type;

   // configuration register file
   typedef struct packed {
      logic [LEN_W-1:0] mismatch_single;
      logic [LEN_W-1:0] mismatch_double;
      logic [LEN_W-1:0] read_i7_length;
      logic [LEN_W-1:0] read_i5_length;
      logic             reverse_i5;
   } csr_type;

   // watson-crick complement, N and unused codes unchanged
   function automatic logic [2:0] base_complement(input logic [2:0] b);
      logic [2:0] c;
      case (b)
         BASE_A:  c = BASE_T;
         BASE_C:  c = BASE_G;
         BASE_G:  c = BASE_C;
         BASE_T:  c = BASE_A;
         default: c = b;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- sv/dibc_ram.sv -----
// dibc_ram: generic single-port-write, single-port-read ram with registered read
// depends on nothing
`default_nettype none

module dibc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- sv/dual_index_barcode_classifier.sv -----
// dual_index_barcode_classifier: sample table load and hamming-distance read classifier
// depends on dibc_pkg and dibc_ram
`default_nettype none

// Loads and classifies go in on start while busy is low. A load captures the beat,
// then writes the entry to the sample ram. A classify reads each of the DEPTH slots
// in turn through the single read port, checks each entry in the cycle after its read
// with one shared compare unit, then shows rsp_outcome and rsp_sample_slot with
// rsp_strobe high for exactly one cycle.
// The receiver cannot stall; a result must be taken when shown. DEPTH is the smaller of
// TABLE_ENTRIES and the 64 slots that entry_slot can address; loads to higher slots are
// dropped. Slot valid bits clear at reset, so no clearing pass is needed. Configuration
// writes go in at any edge with csr_we high and must be made while the block is idle.

module dual_index_barcode_classifier #(
   parameter int TABLE_ENTRIES   = 64,
   parameter int MAX_INDEX_BASES = 12
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_type,
   input  wire logic [dibc_pkg::LANE_W-1:0]          req_lane,
   input  wire logic [dibc_pkg::SLOT_W-1:0]          req_entry_slot,
   input  wire logic [3*MAX_INDEX_BASES-1:0]         req_i7_bases,
   input  wire logic [dibc_pkg::LEN_W-1:0]           req_i7_length,
   input  wire logic [3*MAX_INDEX_BASES-1:0]         req_i5_bases,
   input  wire logic [dibc_pkg::LEN_W-1:0]           req_i5_length,
   input  wire logic                                 csr_we,
   input  wire dibc_pkg::csr_index_type              csr_index,
   input  wire logic [dibc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                      rsp_strobe,
   output dibc_pkg::outcome_type                     rsp_outcome,
   output logic [dibc_pkg::SLOT_W-1:0]               rsp_sample_slot
);

   import dibc_pkg::*;

   localparam int SLOTS   = 1 << SLOT_W;
   localparam int DEPTH   = (TABLE_ENTRIES < SLOTS) ? TABLE_ENTRIES : SLOTS;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int BW      = 3 * MAX_INDEX_BASES;
   localparam int PW      = (MAX_INDEX_BASES > 1) ? $clog2(MAX_INDEX_BASES) : 1;
   localparam int DW      = $clog2(MAX_INDEX_BASES + 1);

   // one sample table entry as stored in the ram
   typedef struct packed {
      logic [LANE_W-1:0] lane;
      logic [BW-1:0]     i7_bases;
      logic [LEN_W-1:0]  i7_len;
      logic [BW-1:0]     i5_bases;
      logic [LEN_W-1:0]  i5_len;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // captured request beat, lengths already clipped to the base limit
   typedef struct packed {
      logic              kind;
      logic [LANE_W-1:0] lane;
      logic [SLOT_W-1:0] slot;
      logic [BW-1:0]     i7_bases;
      logic [LEN_W-1:0]  i7_len;
      logic [BW-1:0]     i5_bases;
      logic [LEN_W-1:0]  i5_len;
   } req_type_t_type;

   // clip a length to the number of bases a word holds
   function automatic logic [LEN_W-1:0] clip_max(input logic [LEN_W-1:0] n);
      logic [LEN_W-1:0] r;
      r = n;
      if (int'(n) > MAX_INDEX_BASES) begin
         r = LEN_W'(MAX_INDEX_BASES);
      end
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] min_len(input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b);
      return (a > b) ? b : a;
   endfunction

   // zero every base at or beyond len
   function automatic logic [BW-1:0] keep_bases(input logic [BW-1:0]    bases,
                                                input logic [LEN_W-1:0] len);
      logic [BW-1:0] r;
      r = '0;
      for (int k = 0; k < MAX_INDEX_BASES; k++) begin
         if (k < int'(len)) begin
            r[3*k +: 3] = bases[3*k +: 3];
         end
      end
      return r;
   endfunction

   // mismatching bases over the first len positions
   function automatic logic [DW-1:0] hamming(input logic [BW-1:0]    a,
                                             input logic [BW-1:0]    b,
                                             input logic [LEN_W-1:0] len);
      logic [MAX_INDEX_BASES-1:0] diff;
      for (int k = 0; k < MAX_INDEX_BASES; k++) begin
         diff[k] = (k < int'(len)) && (a[3*k +: 3] != b[3*k +: 3]);
      end
      return DW'($countones(diff));
   endfunction

   state_type       state_ff, state_in;
   csr_type         csr_ff, csr_in;
   req_type_t_type  req_ff, req_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            rd_vld_ff, rd_vld_in;
   logic            rd_valid_ff, rd_valid_in;
   logic [AW-1:0]   rd_slot_ff, rd_slot_in;
   logic [DEPTH-1:0] entry_valid_ff, entry_valid_in;
   logic [1:0]      n_double_ff, n_double_in;
   logic [1:0]      n_single_ff, n_single_in;
   logic [AW-1:0]   hit_double_ff, hit_double_in;
   logic [AW-1:0]   hit_single_ff, hit_single_in;

   logic            accept;
   logic            ram_we;
   logic            rd_en;
   entry_type       load_word;
   entry_type       rd_entry;
   logic [ENTRY_W-1:0] rd_data;
   logic            is_double_hit;
   logic            is_single_hit;

   assign accept   = start && (state_ff == ST_IDLE);
   assign rd_entry = entry_type'(rd_data);

   // sample table storage
   dibc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_ff.slot[AW-1:0]),
      .wr_data (load_word),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_type == REQ_LOAD) ? ST_LOAD : ST_SCAN;
            end
         end
         ST_LOAD: state_in = ST_IDLE;
         ST_SCAN: begin
            if (int'(cnt_ff) == DEPTH) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy       = 1'b1;
      ram_we     = 1'b0;
      rd_en      = 1'b0;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_LOAD: ram_we = (int'(req_ff.slot) < DEPTH);
         ST_SCAN: rd_en = (int'(cnt_ff) < DEPTH);
         ST_DONE: rsp_strobe = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   // csr writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MISMATCH_SINGLE: csr_in.mismatch_single = csr_wdata;
            CSR_MISMATCH_DOUBLE: csr_in.mismatch_double = csr_wdata;
            CSR_READ_I7_LENGTH:  csr_in.read_i7_length  = csr_wdata;
            CSR_READ_I5_LENGTH:  csr_in.read_i5_length  = csr_wdata;
            CSR_REVERSE_I5:      csr_in.reverse_i5      = csr_wdata[0];
            default:             csr_in = csr_ff;
         endcase
      end
   end

   // request capture
   always_comb begin
      req_in = req_ff;
      if (accept) begin
         req_in.kind     = req_type;
         req_in.lane     = req_lane;
         req_in.slot     = req_entry_slot;
         req_in.i7_bases = req_i7_bases;
         req_in.i7_len   = clip_max(req_i7_length);
         req_in.i5_bases = req_i5_bases;
         req_in.i5_len   = clip_max(req_i5_length);
      end
   end

   // entry build for a load: optional reverse complement, then truncation
   always_comb begin
      logic [LEN_W-1:0] l7;
      logic [LEN_W-1:0] l5;
      logic [BW-1:0]    b5;
      logic [PW-1:0]    src;
      l7  = min_len(req_ff.i7_len, csr_ff.read_i7_length);
      l5  = min_len(req_ff.i5_len, csr_ff.read_i5_length);
      b5  = req_ff.i5_bases;
      src = '0;
      if (csr_ff.reverse_i5) begin
         b5 = '0;
         for (int k = 0; k < MAX_INDEX_BASES; k++) begin
            if (k < int'(req_ff.i5_len)) begin
               src = PW'(int'(req_ff.i5_len) - 1 - k);
               b5[3*k +: 3] = base_complement(req_ff.i5_bases[3*src +: 3]);
            end
         end
      end
      load_word.lane     = req_ff.lane;
      load_word.i7_len   = l7;
      load_word.i7_bases = keep_bases(req_ff.i7_bases, l7);
      load_word.i5_len   = (l7 == '0) ? '0 : l5;
      load_word.i5_bases = (l7 == '0) ? '0 : keep_bases(b5, l5);
   end

   // slot valid bits follow the stored i7 length
   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (ram_we) begin
         entry_valid_in[req_ff.slot[AW-1:0]] = (load_word.i7_len != '0);
      end
   end

   // scan address and read pipeline
   always_comb begin
      cnt_in      = cnt_ff;
      rd_vld_in   = rd_en;
      rd_slot_in  = cnt_ff[AW-1:0];
      rd_valid_in = 1'b0;
      if (accept) begin
         cnt_in = '0;
      end else if (rd_en) begin
         cnt_in      = cnt_ff + 1'b1;
         rd_valid_in = entry_valid_ff[cnt_ff[AW-1:0]];
      end
   end

   // shared compare unit: one entry against the read per cycle
   always_comb begin
      logic [DW-1:0] h7;
      logic [DW-1:0] h5;
      logic          cand;
      h7   = hamming(req_ff.i7_bases, rd_entry.i7_bases, rd_entry.i7_len);
      h5   = hamming(req_ff.i5_bases, rd_entry.i5_bases, rd_entry.i5_len);
      cand = rd_vld_ff && rd_valid_ff && (rd_entry.lane == req_ff.lane) &&
             (req_ff.i7_len >= rd_entry.i7_len);
      is_double_hit = cand && (rd_entry.i5_len != '0) &&
                      (req_ff.i5_len >= rd_entry.i5_len) &&
                      (int'(h7) <= int'(csr_ff.mismatch_double)) &&
                      (int'(h5) <= int'(csr_ff.mismatch_double));
      is_single_hit = cand && (rd_entry.i5_len == '0) &&
                      (int'(h7) <= int'(csr_ff.mismatch_single));
   end

   // match tallies, saturating at two
   always_comb begin
      n_double_in   = n_double_ff;
      n_single_in   = n_single_ff;
      hit_double_in = hit_double_ff;
      hit_single_in = hit_single_ff;
      if (accept) begin
         n_double_in = '0;
         n_single_in = '0;
      end else begin
         if (is_double_hit) begin
            if (n_double_ff == 2'd0) begin
               hit_double_in = rd_slot_ff;
            end
            if (n_double_ff != 2'd2) begin
               n_double_in = n_double_ff + 1'b1;
            end
         end
         if (is_single_hit) begin
            if (n_single_ff == 2'd0) begin
               hit_single_in = rd_slot_ff;
            end
            if (n_single_ff != 2'd2) begin
               n_single_in = n_single_ff + 1'b1;
            end
         end
      end
   end

   // result beat: double matches win over single ones
   always_comb begin
      rsp_outcome     = OUT_UNASSIGNED;
      rsp_sample_slot = '0;
      if (n_double_ff == 2'd1) begin
         rsp_outcome     = OUT_DOUBLE;
         rsp_sample_slot = SLOT_W'(hit_double_ff);
      end else if (n_double_ff == 2'd2) begin
         rsp_outcome = OUT_DOUBLE_AMBIG;
      end else if (n_single_ff == 2'd1) begin
         rsp_outcome     = OUT_SINGLE;
         rsp_sample_slot = SLOT_W'(hit_single_ff);
      end else if (n_single_ff == 2'd2) begin
         rsp_outcome = OUT_SINGLE_AMBIG;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                <= ST_IDLE;
         csr_ff.mismatch_single  <= LEN_W'(1);
         csr_ff.mismatch_double  <= LEN_W'(2);
         csr_ff.read_i7_length   <= LEN_W'(8);
         csr_ff.read_i5_length   <= LEN_W'(8);
         csr_ff.reverse_i5       <= 1'b0;
         entry_valid_ff          <= '0;
         cnt_ff                  <= '0;
         rd_vld_ff               <= 1'b0;
         n_double_ff             <= '0;
         n_single_ff             <= '0;
      end else begin
         state_ff       <= state_in;
         csr_ff         <= csr_in;
         entry_valid_ff <= entry_valid_in;
         cnt_ff         <= cnt_in;
         rd_vld_ff      <= rd_vld_in;
         n_double_ff    <= n_double_in;
         n_single_ff    <= n_single_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rd_slot_ff    <= rd_slot_in;
      rd_valid_ff   <= rd_valid_in;
      hit_double_ff <= hit_double_in;
      hit_single_ff <= hit_single_in;
   end

   // a result beat only ever follows the end of a scan
   a_strobe_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_SCAN)
      else $error("result beat without a finished scan");

   // an accepted request makes the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start the sequencer");

   // a slot is reported only for an assigned outcome
   a_slot_only_assigned: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_outcome != OUT_SINGLE && rsp_outcome != OUT_DOUBLE)
         |-> rsp_sample_slot == '0)
      else $error("sample slot set on an unassigned or ambiguous result");

   // an assigned double match points at a live entry
   a_double_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_outcome == OUT_DOUBLE) |-> entry_valid_ff[hit_double_ff])
      else $error("double match reported on an empty slot");

endmodule

`default_nettype wire
